FILE: sv/sipq_pkg.sv
// Package: shared types and codes for the sorted-insert priority queue.
`timescale 1ns / 1ps
package sipq_pkg;

   localparam int unsigned ValueWidth  = 32;
   localparam int unsigned StatusWidth = 2;

   typedef logic [ValueWidth-1:0]  value_type;
   typedef logic [StatusWidth-1:0] status_type;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   localparam status_type STATUS_INSERTED  = 2'd0;
   localparam status_type STATUS_REMOVED   = 2'd1;
   localparam status_type STATUS_OVERFLOW  = 2'd2;
   localparam status_type STATUS_UNDERFLOW = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PLACE,
      ST_POP,
      ST_REPLY
   } state_type;

endpackage

FILE: sv/sipq_if.sv
// Interfaces: request and response channels of the priority queue.
`timescale 1ns / 1ps
interface sipq_req_if import sipq_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      func;
   value_type in_value;

   modport source (output valid, output func, output in_value, input ready);
   modport sink (input valid, input func, input in_value, output ready);
endinterface

interface sipq_rsp_if import sipq_pkg::*; ();
   logic       valid;
   logic       ready;
   value_type  out_value;
   status_type status;

   modport source (output valid, output out_value, output status, input ready);
   modport sink (input valid, input out_value, input status, output ready);
endinterface

FILE: sv/sipq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sipq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/sorted_insert_priority_queue.sv
// Top level: bounded priority queue of signed values kept sorted in a ring RAM.
//
// Usage:
//   req_ch carries one beat per operation: func 0 inserts in_value, func 1
//   removes the largest entry. rsp_ch returns exactly one beat per request
//   with status (inserted, removed, overflow, underflow) and out_value,
//   which is nonzero only for a remove.
//   An insert walks from the tail toward the head, moving one smaller entry
//   per cycle through the slot RAM; it moves up to DEPTH-1 entries, and
//   the one read port of the slot RAM paces the walk.
//   req_ch.ready is high only while no operation is in progress; the next
//   request is taken while a finished response still waits in the output
//   register.
//   When rsp_ch stalls, the final step of the next operation waits until the
//   output register frees up; nothing is lost or reordered.
//   Reset clears head and count; slot contents need no clearing.
`timescale 1ns / 1ps
module sorted_insert_priority_queue import sipq_pkg::*; #(
   parameter int unsigned DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   sipq_req_if.sink    req_ch,
   sipq_rsp_if.source  rsp_ch
);

   localparam int unsigned IdxW = $clog2(DEPTH);
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   state_type        state_ff, state_in;
   logic [IdxW-1:0]  head_ff, head_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [CntW-1:0]  pos_ff, pos_in;
   value_type        value_ff, value_in;
   status_type       status_ff, status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   value_type        rsp_value_ff, rsp_value_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic             ram_we, ram_re;
   logic [IdxW-1:0]  ram_waddr, ram_raddr;
   value_type        ram_wdata, ram_rdata;
   logic             out_free;

   function automatic logic [IdxW-1:0] ring_pos(input logic [IdxW-1:0] head,
                                                input logic [CntW-1:0] off);
      logic [CntW:0] sum;
      sum = (CntW+1)'(head) + (CntW+1)'(off);
      if (sum >= (CntW+1)'(DEPTH)) begin
         sum = sum - (CntW+1)'(DEPTH);
      end
      return IdxW'(sum);
   endfunction

   sipq_ram #(
      .WIDTH (ValueWidth),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = ring_pos(head_ff, pos_ff);
      ram_wdata     = value_ff;
      ram_re        = 1'b0;
      ram_raddr     = head_ff;
      req_ch.ready  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               value_in = req_ch.in_value;
               if (req_ch.func == FUNC_REMOVE) begin
                  if (count_ff == '0) begin
                     status_in = STATUS_UNDERFLOW;
                     state_in  = ST_REPLY;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = head_ff;
                     state_in  = ST_POP;
                  end
               end else if (count_ff == CntW'(DEPTH)) begin
                  status_in = STATUS_OVERFLOW;
                  state_in  = ST_REPLY;
               end else if (count_ff == '0) begin
                  pos_in   = '0;
                  state_in = ST_PLACE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = ring_pos(head_ff, count_ff - CntW'(1));
                  pos_in    = count_ff;
                  state_in  = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            // ram_rdata holds the entry just ahead of pos
            if ($signed(value_ff) > $signed(ram_rdata)) begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata;
               pos_in    = pos_ff - CntW'(1);
               if (pos_ff == CntW'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = ring_pos(head_ff, pos_ff - CntW'(2));
               end
            end else if (out_free) begin
               ram_we        = 1'b1;
               count_in      = count_ff + CntW'(1);
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = STATUS_INSERTED;
               state_in      = ST_IDLE;
            end
         end
         ST_PLACE: begin
            if (out_free) begin
               ram_we        = 1'b1;
               count_in      = count_ff + CntW'(1);
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = STATUS_INSERTED;
               state_in      = ST_IDLE;
            end
         end
         ST_POP: begin
            if (out_free) begin
               head_in       = ring_pos(head_ff, CntW'(1));
               count_in      = count_ff - CntW'(1);
               rsp_valid_in  = 1'b1;
               rsp_value_in  = ram_rdata;
               rsp_status_in = STATUS_REMOVED;
               state_in      = ST_IDLE;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_value = rsp_value_ff;
   assign rsp_ch.status    = rsp_status_ff;

endmodule

FILE: bench/sorted_insert_priority_queue_tb.sv
// Testbench: checks the sorted-insert priority queue against a behavioral copy of its sorted ring.
`timescale 1ns / 1ps
module sorted_insert_priority_queue_tb;
   import sipq_pkg::*;

   localparam int Depth         = 8;
   localparam int HeadW         = $clog2(Depth);
   localparam int CountW        = $clog2(Depth) + 1;
   localparam int NumDirected   = 25;
   localparam int ItemsPerPhase = 350;
   localparam int HoldCycles    = 80;

   typedef struct packed {
      logic       func;
      value_type  value;
      logic       typed;
      value_type  exp_value;
      status_type exp_status;
   } directed_row_type;

   typedef struct packed {
      value_type  out_value;
      status_type status;
   } queue_reply_type;

   // typed rows: empty remove, first inserts, full insert, removes of the maximum
   localparam directed_row_type DirectedRows [NumDirected] = '{
      '{FUNC_REMOVE, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_UNDERFLOW},
      '{FUNC_INSERT, 32'h8000_0000, 1'b1, 32'h0000_0000, STATUS_INSERTED},
      '{FUNC_INSERT, 32'h7fff_ffff, 1'b1, 32'h0000_0000, STATUS_INSERTED},
      '{FUNC_INSERT, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_INSERTED},
      '{FUNC_INSERT, 32'hffff_ffff, 1'b0, 32'h0000_0000, STATUS_INSERTED},
      '{FUNC_INSERT, 32'h0000_0001, 1'b0, 32'h0000_0000, STATUS_INSERTED},
      '{FUNC_INSERT, 32'h0000_0005, 1'b0, 32'h0000_0000, STATUS_INSERTED},
      '{FUNC_INSERT, 32'h0000_0005, 1'b0, 32'h0000_0000, STATUS_INSERTED},
      '{FUNC_INSERT, 32'h7fff_ffff, 1'b0, 32'h0000_0000, STATUS_INSERTED},
      '{FUNC_INSERT, 32'h0000_0003, 1'b1, 32'h0000_0000, STATUS_OVERFLOW},
      '{FUNC_REMOVE, 32'h0000_0000, 1'b1, 32'h7fff_ffff, STATUS_REMOVED},
      '{FUNC_REMOVE, 32'h0000_0000, 1'b1, 32'h7fff_ffff, STATUS_REMOVED},
      '{FUNC_INSERT, 32'h8000_0000, 1'b0, 32'h0000_0000, STATUS_INSERTED},
      '{FUNC_REMOVE, 32'hdead_beef, 1'b0, 32'h0000_0000, STATUS_REMOVED},
      '{FUNC_REMOVE, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_REMOVED},
      '{FUNC_REMOVE, 32'hffff_ffff, 1'b0, 32'h0000_0000, STATUS_REMOVED},
      '{FUNC_REMOVE, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_REMOVED},
      '{FUNC_REMOVE, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_REMOVED},
      '{FUNC_REMOVE, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_REMOVED},
      '{FUNC_REMOVE, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_REMOVED},
      '{FUNC_REMOVE, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_UNDERFLOW},
      '{FUNC_INSERT, 32'h5555_5555, 1'b0, 32'h0000_0000, STATUS_INSERTED},
      '{FUNC_INSERT, 32'haaaa_aaaa, 1'b0, 32'h0000_0000, STATUS_INSERTED},
      '{FUNC_REMOVE, 32'h0000_0000, 1'b1, 32'h5555_5555, STATUS_REMOVED},
      '{FUNC_REMOVE, 32'h0000_0000, 1'b0, 32'h0000_0000, STATUS_REMOVED}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   sipq_req_if req_ch ();
   sipq_rsp_if rsp_ch ();

   sorted_insert_priority_queue #(.DEPTH(Depth)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic signed [31:0]         ring_slots [Depth];
   logic [HeadW-1:0]           ring_head;
   logic [CountW-1:0]          ring_count;

   queue_reply_type pending_replies [$];
   int mismatches = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;

   always #10 clock = ~clock;

   function automatic queue_reply_type apply_queue_op(input logic func, input value_type value);
      queue_reply_type reply;
      int pos;
      reply.out_value = '0;
      if (func == FUNC_INSERT) begin
         if (int'(ring_count) >= Depth) begin
            reply.status = STATUS_OVERFLOW;
         end else begin
            pos = int'(ring_count);
            while (pos > 0 && $signed(value) > ring_slots[(int'(ring_head) + pos - 1) % Depth]) begin
               ring_slots[(int'(ring_head) + pos) % Depth] =
                  ring_slots[(int'(ring_head) + pos - 1) % Depth];
               pos--;
            end
            ring_slots[(int'(ring_head) + pos) % Depth] = value;
            ring_count = ring_count + CountW'(1);
            reply.status = STATUS_INSERTED;
         end
      end else begin
         if (ring_count == '0) begin
            reply.status = STATUS_UNDERFLOW;
         end else begin
            reply.out_value = ring_slots[ring_head];
            ring_head = HeadW'((int'(ring_head) + 1) % Depth);
            ring_count = ring_count - CountW'(1);
            reply.status = STATUS_REMOVED;
         end
      end
      return reply;
   endfunction

   // valid stays high from one beat to the next unless the sender idles first
   task automatic send_op(input logic func, input value_type value, input logic typed,
                          input queue_reply_type typed_reply);
      queue_reply_type predicted;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.func     <= func;
      req_ch.in_value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = apply_queue_op(func, value);
      pending_replies.push_back(typed ? typed_reply : predicted);
   endtask

   task automatic drain_queue();
      req_ch.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left = HoldCycles;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      queue_reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: out_value %h status %0d", rsp_ch.out_value,
                        rsp_ch.status);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_ch.out_value !== want.out_value || rsp_ch.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: out_value %h exp %h, status %0d exp %0d",
                           rsp_ch.out_value, want.out_value, rsp_ch.status, want.status);
            end
         end
      end
   end

   initial begin
      int phase;
      int i;
      int insert_bias;
      int draw;
      logic func;
      value_type value;
      queue_reply_type typed_reply;

      req_ch.valid    = 1'b0;
      req_ch.func     = FUNC_INSERT;
      req_ch.in_value = '0;
      rsp_ch.ready    = 1'b0;
      ring_head       = '0;
      ring_count      = '0;
      foreach (ring_slots[k]) ring_slots[k] = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < NumDirected; i++) begin
         typed_reply.out_value = DirectedRows[i].exp_value;
         typed_reply.status    = DirectedRows[i].exp_status;
         send_op(DirectedRows[i].func, DirectedRows[i].value, DirectedRows[i].typed,
                 typed_reply);
      end
      drain_queue();

      insert_bias = 50;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 49; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 49; end
            default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
         endcase
         for (i = 0; i < ItemsPerPhase; i++) begin
            if (i % 40 == 0) begin
               draw = $urandom_range(0, 2);
               insert_bias = (draw == 0) ? 15 : (draw == 1) ? 50 : 85;
            end
            if (i == 120 && (phase == 0 || phase == 3))
               hold_requests++;
            func = ($urandom_range(0, 99) < insert_bias) ? FUNC_INSERT : FUNC_REMOVE;
            draw = $urandom_range(0, 9);
            case (draw)
               0, 1, 2, 3: value = $urandom;
               4, 5, 6:    value = $urandom_range(0, 8) - 4;
               7:          value = 32'h7fff_ffff;
               8:          value = 32'h8000_0000;
               default:    value = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0001;
            endcase
            typed_reply = '0;
            send_op(func, value, 1'b0, typed_reply);
         end
         drain_queue();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_replies.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: files.f
sv/sipq_pkg.sv
sv/sipq_if.sv
sv/sipq_ram.sv
sv/sorted_insert_priority_queue.sv
bench/sorted_insert_priority_queue_tb.sv
